/* src/meter_reply_frame_receiver_macros.svh */
// assertion macros for the meter reply frame receiver
// used at the end of the top level, no other dependencies
`ifndef METER_REPLY_FRAME_RECEIVER_MACROS_SVH
`define METER_REPLY_FRAME_RECEIVER_MACROS_SVH

// condition must hold at every clock edge outside reset
`define MRFR_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MRFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/mrfr_pkg.sv */
// shared types and constants for the meter reply frame receiver
// no dependencies
package mrfr_pkg;

    localparam int FRAME_BYTES_MAX_DEF = 1024;

    localparam logic [7:0] HEADER_RESET = 8'hFE;
    localparam logic [7:0] OFFSET_RESET = 8'h33;

    // register index, taken from paddr[2]
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] check_offset;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  register_count;
        logic [63:0] saved_reply;
        logic        reply_kept;
        logic        check_ok;
        logic        frame_kind;
    } result_t;

endpackage

/* src/mrfr_cfg_regs.sv */
// apb configuration registers: header byte and checksum offset
// depends on mrfr_pkg
module mrfr_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output mrfr_pkg::cfg_t     cfg
);

    logic [7:0] header_reg;
    logic [7:0] header_next;
    logic [7:0] offset_reg;
    logic [7:0] offset_next;
    logic       wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        header_next = header_reg;
        offset_next = offset_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                mrfr_pkg::REG_HEADER: header_next = pwdata[7:0];
                mrfr_pkg::REG_OFFSET: offset_next = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= mrfr_pkg::HEADER_RESET;
            offset_reg <= mrfr_pkg::OFFSET_RESET;
        end
        else
        begin
            header_reg <= header_next;
            offset_reg <= offset_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mrfr_pkg::REG_HEADER: prdata = {24'b0, header_reg};
            mrfr_pkg::REG_OFFSET: prdata = {24'b0, offset_reg};
            default:              prdata = 32'b0;
        endcase
    end

    assign cfg.header_byte  = header_reg;
    assign cfg.check_offset = offset_reg;

endmodule

/* src/mrfr_parser.sv */
// input byte register and frame parser: phase, index, sum, frame head, saved reply
// depends on mrfr_pkg
module mrfr_parser
#(
    parameter int FRAME_BYTES_MAX = mrfr_pkg::FRAME_BYTES_MAX_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mrfr_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    input  logic                res_ready,
    output logic                res_valid,
    output mrfr_pkg::result_t   res
);

    localparam int LIM_W = ($clog2(FRAME_BYTES_MAX + 1) > 11) ?
                           $clog2(FRAME_BYTES_MAX + 1) : 11;
    localparam logic [LIM_W-1:0] FRAME_LIM = LIM_W'(FRAME_BYTES_MAX);
    localparam logic [3:0] NIB_WRITE = 4'h2;
    localparam logic [3:0] NIB_READ  = 4'h1;

    typedef enum logic [6:0] {
        PH_HUNT  = 7'b0000001,
        PH_CMD   = 7'b0000010,
        PH_WDATA = 7'b0000100,
        PH_WCHK  = 7'b0001000,
        PH_COUNT = 7'b0010000,
        PH_DATA  = 7'b0100000,
        PH_RCHK  = 7'b1000000
    } phase_t;

    logic        byte_valid_reg;
    logic        byte_valid_next;
    logic [7:0]  byte_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [10:0] byte_index_reg;
    logic [10:0] byte_index_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [9:0]  data_length_reg;
    logic [9:0]  data_length_next;
    logic        reply_kind_reg;
    logic        reply_kind_next;
    logic [63:0] frame_head_reg;
    logic [63:0] frame_head_next;
    logic [63:0] kept_reply_reg;
    logic [63:0] kept_reply_next;

    logic        step;
    logic        load;
    logic [63:0] head_take;
    logic [7:0]  sum_take;
    logic [10:0] index_take;
    logic [7:0]  expected;
    logic        check_ok;
    logic        keep;
    logic [9:0]  count_len;
    logic [LIM_W-1:0] frame_len;

    assign step     = byte_valid_reg && res_ready;
    assign in_ready = !byte_valid_reg || res_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
            byte_valid_next = 1'b1;
        else if (step)
            byte_valid_next = 1'b0;
        else
            byte_valid_next = byte_valid_reg;
    end

    // byte accumulation shared by most phases
    always_comb
    begin
        if (byte_index_reg[10:3] == 8'b0)
            head_take = frame_head_reg |
                        ({56'b0, byte_reg} << {byte_index_reg[2:0], 3'b000});
        else
            head_take = frame_head_reg;
        sum_take   = sum_reg + byte_reg;
        index_take = byte_index_reg + 11'd1;
    end

    assign expected  = ~sum_reg + cfg.check_offset;
    assign check_ok  = (byte_reg == expected);
    assign keep      = check_ok && (data_length_reg <= 10'd4);
    assign count_len = {byte_reg, 2'b00};
    assign frame_len = LIM_W'(count_len) + LIM_W'(4);

    always_comb
    begin
        phase_next         = phase_reg;
        byte_index_next    = byte_index_reg;
        sum_next           = sum_reg;
        data_length_next   = data_length_reg;
        reply_kind_next    = reply_kind_reg;
        frame_head_next    = frame_head_reg;
        kept_reply_next    = kept_reply_reg;
        res_valid          = 1'b0;
        res.frame_kind     = reply_kind_reg;
        res.check_ok       = check_ok;
        res.reply_kept     = 1'b0;
        res.saved_reply    = kept_reply_reg;
        res.register_count = data_length_reg[9:2];
        if (step)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (byte_reg == cfg.header_byte)
                    begin
                        frame_head_next  = {56'b0, byte_reg};
                        sum_next         = byte_reg;
                        byte_index_next  = 11'd1;
                        data_length_next = 10'd0;
                        phase_next       = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    frame_head_next = head_take;
                    sum_next        = sum_take;
                    byte_index_next = index_take;
                    if (byte_reg[3:0] == NIB_WRITE)
                    begin
                        reply_kind_next = 1'b0;
                        phase_next      = PH_WDATA;
                    end
                    else if (byte_reg[3:0] == NIB_READ)
                    begin
                        reply_kind_next = 1'b1;
                        phase_next      = PH_COUNT;
                    end
                    else
                        phase_next = PH_HUNT;
                end
                PH_WDATA:
                begin
                    frame_head_next = head_take;
                    sum_next        = sum_take;
                    byte_index_next = index_take;
                    phase_next      = PH_WCHK;
                end
                PH_WCHK:
                begin
                    res_valid          = 1'b1;
                    res.register_count = 8'd0;
                    phase_next         = PH_HUNT;
                    byte_index_next    = 11'd0;
                end
                PH_COUNT:
                begin
                    frame_head_next  = head_take;
                    sum_next         = sum_take;
                    byte_index_next  = index_take;
                    data_length_next = count_len;
                    if (frame_len > FRAME_LIM)
                    begin
                        phase_next      = PH_HUNT;
                        byte_index_next = 11'd0;
                    end
                    else if (byte_reg == 8'd0)
                        phase_next = PH_RCHK;
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    frame_head_next = head_take;
                    sum_next        = sum_take;
                    byte_index_next = index_take;
                    if (index_take >= ({1'b0, data_length_reg} + 11'd3))
                        phase_next = PH_RCHK;
                end
                PH_RCHK:
                begin
                    frame_head_next = head_take;
                    res_valid       = 1'b1;
                    res.reply_kept  = keep;
                    if (keep)
                    begin
                        kept_reply_next = head_take;
                        res.saved_reply = head_take;
                    end
                    phase_next      = PH_HUNT;
                    byte_index_next = 11'd0;
                end
                default:
                begin
                    phase_next      = PH_HUNT;
                    byte_index_next = 11'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg  <= 1'b0;
            phase_reg       <= PH_HUNT;
            byte_index_reg  <= 11'd0;
            sum_reg         <= 8'd0;
            data_length_reg <= 10'd0;
            reply_kind_reg  <= 1'b0;
            frame_head_reg  <= 64'd0;
            kept_reply_reg  <= 64'd0;
        end
        else
        begin
            byte_valid_reg  <= byte_valid_next;
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            sum_reg         <= sum_next;
            data_length_reg <= data_length_next;
            reply_kind_reg  <= reply_kind_next;
            frame_head_reg  <= frame_head_next;
            kept_reply_reg  <= kept_reply_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            byte_reg <= in_byte;
    end

endmodule

/* src/mrfr_out_reg.sv */
// result register between the parser and the master stream side
// depends on mrfr_pkg
module mrfr_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  mrfr_pkg::result_t   res,
    output logic                res_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output mrfr_pkg::result_t   out_res
);

    logic              valid_reg;
    logic              valid_next;
    mrfr_pkg::result_t data_reg;

    assign res_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (res_ready)
            valid_next = res_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            data_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

/* src/meter_reply_frame_receiver.sv */
// a result word leaves after its checksum byte is accepted, passing through the input byte
// register, then the result register
// throughput: one byte per cycle while s_tready is high, set by the single-step parser update
// ready drops only while a finished result waits at the master side
// reset (async, active low) returns to header hunt, clears sum, index and saved
// reply, and loads header 0xfe and offset 0x33
module meter_reply_frame_receiver
#(
    parameter int FRAME_BYTES_MAX = mrfr_pkg::FRAME_BYTES_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // check_ok, reply_kept, saved_reply, register_count, pad
    output logic [0:0]  m_tuser     // frame_kind
);

`include "meter_reply_frame_receiver_macros.svh"

    mrfr_pkg::cfg_t    cfg;
    mrfr_pkg::result_t res;
    mrfr_pkg::result_t out_res;
    logic              res_valid;
    logic              res_ready;

    assign pready = 1'b1;

    mrfr_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mrfr_parser
    #(
        .FRAME_BYTES_MAX (FRAME_BYTES_MAX)
    )
    u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    mrfr_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'b0, out_res.register_count, out_res.saved_reply,
                      out_res.reply_kept, out_res.check_ok};
    assign m_tuser = out_res.frame_kind;

    `MRFR_ASSERT_IMPLY(a_kept_only_read, m_tvalid && m_tdata[1], m_tuser[0], "write reply kept")
    `MRFR_ASSERT_IMPLY(a_no_result_drop, res_valid, res_ready, "result lost at output register")
    `MRFR_ASSERT_IMPLY(a_stall_source, !s_tready, m_tvalid && !m_tready, "input stalled without cause")
    `MRFR_ASSERT_IMPLY(a_write_count, m_tvalid && !m_tuser[0], m_tdata[73:66] == 8'd0, "write count nonzero")

endmodule

/* tb/mrfr_tb_pkg.sv */
// command codes and frame_kind values shared by the stimulus and the checker of the meter reply frame receiver
// no dependencies
package mrfr_tb_pkg;

    // low nibble of the command byte
    localparam logic [3:0] CMD_READ  = 4'h1;
    localparam logic [3:0] CMD_WRITE = 4'h2;

    // frame_kind values
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

endpackage

/* tb/meter_reply_frame_receiver_checker.sv */
// checker for the meter reply frame receiver: follows the register bus and both streams,
// predicts each result word from the accepted bytes and compares it field by field
// depends on mrfr_pkg and mrfr_tb_pkg
module meter_reply_frame_receiver_checker
    import mrfr_pkg::*;
    import mrfr_tb_pkg::*;
#(
    parameter int FRAME_BYTES_MAX = mrfr_pkg::FRAME_BYTES_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          fail_count,
    output int          replies_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_CMD,
        ST_WDATA,
        ST_WCHK,
        ST_COUNT,
        ST_DATA,
        ST_RCHK
    } parse_state_t;

    logic [7:0]   hdr_byte;
    logic [7:0]   chk_offset;
    parse_state_t state;
    logic [10:0]  idx;
    logic [7:0]   run_sum;
    logic [9:0]   dlen;
    logic [63:0]  head;
    logic [63:0]  kept;
    result_t      reply_q[$];
    int           mismatches;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("meter_reply_frame_receiver_checker: %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic absorb(input logic [7:0] b);
        if (idx < 8)
            head[idx*8 +: 8] = b;
        run_sum = run_sum + b;
        idx = idx + 1'b1;
    endtask

    // advance the frame parser by one byte, giving the result word it causes if any
    task automatic parse_byte(input logic [7:0] b, output bit done, output result_t want);
        logic [7:0] chk_want;
        bit         good;
        done = 1'b0;
        want = '0;
        chk_want = ~run_sum + chk_offset;
        case (state)
            ST_HUNT:
                if (b == hdr_byte)
                begin
                    head = '0;
                    run_sum = '0;
                    idx = '0;
                    dlen = '0;
                    absorb(b);
                    state = ST_CMD;
                end
            ST_CMD:
            begin
                absorb(b);
                if (b[3:0] == CMD_WRITE)
                    state = ST_WDATA;
                else if (b[3:0] == CMD_READ)
                    state = ST_COUNT;
                else
                    state = ST_HUNT;
            end
            ST_WDATA:
            begin
                absorb(b);
                state = ST_WCHK;
            end
            ST_WCHK:
            begin
                done = 1'b1;
                want.frame_kind = KIND_WRITE;
                want.check_ok = (b == chk_want);
                want.reply_kept = 1'b0;
                want.saved_reply = kept;
                want.register_count = '0;
                state = ST_HUNT;
                idx = '0;
            end
            ST_COUNT:
            begin
                absorb(b);
                dlen = {b, 2'b00};
                if (int'(dlen) + 4 > FRAME_BYTES_MAX)
                begin
                    state = ST_HUNT;
                    idx = '0;
                end
                else
                    state = (dlen == 0) ? ST_RCHK : ST_DATA;
            end
            ST_DATA:
            begin
                absorb(b);
                if (idx >= 3 + dlen)
                    state = ST_RCHK;
            end
            ST_RCHK:
            begin
                good = (b == chk_want);
                if (idx < 8)
                    head[idx*8 +: 8] = b;
                if (good && dlen <= 4)
                    kept = head;
                done = 1'b1;
                want.frame_kind = KIND_READ;
                want.check_ok = good;
                want.reply_kept = good && (dlen <= 4);
                want.saved_reply = kept;
                want.register_count = dlen[9:2];
                state = ST_HUNT;
                idx = '0;
            end
            default:
            begin
                state = ST_HUNT;
                idx = '0;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bit      done;
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            hdr_byte = HEADER_RESET;
            chk_offset = OFFSET_RESET;
            state = ST_HUNT;
            idx = '0;
            run_sum = '0;
            dlen = '0;
            head = '0;
            kept = '0;
            reply_q.delete();
            mismatches = 0;
            replies_owed <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_HEADER)
                    hdr_byte = pwdata[7:0];
                else
                    chk_offset = pwdata[7:0];
            end
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, done, want);
                if (done)
                    reply_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.frame_kind = m_tuser[0];
                got.check_ok = m_tdata[0];
                got.reply_kept = m_tdata[1];
                got.saved_reply = m_tdata[65:2];
                got.register_count = m_tdata[73:66];
                if (reply_q.size() == 0)
                    report_mismatch($sformatf("result word with none expected: %h", m_tdata));
                else
                begin
                    want = reply_q.pop_front();
                    if (got.frame_kind !== want.frame_kind)
                        report_mismatch($sformatf("frame_kind got %b want %b",
                            got.frame_kind, want.frame_kind));
                    if (got.check_ok !== want.check_ok)
                        report_mismatch($sformatf("check_ok got %b want %b",
                            got.check_ok, want.check_ok));
                    if (got.reply_kept !== want.reply_kept)
                        report_mismatch($sformatf("reply_kept got %b want %b",
                            got.reply_kept, want.reply_kept));
                    if (got.saved_reply !== want.saved_reply)
                        report_mismatch($sformatf("saved_reply got %h want %h",
                            got.saved_reply, want.saved_reply));
                    if (got.register_count !== want.register_count)
                        report_mismatch($sformatf("register_count got %h want %h",
                            got.register_count, want.register_count));
                end
            end
            replies_owed <= reply_q.size();
        end
    end

endmodule

/* tb/meter_reply_frame_receiver_tb.sv */
// top of the meter reply frame receiver testbench: clock, reset, register writes,
// reply frame stimulus with random idling on both streams, and the verdict
// depends on mrfr_pkg, mrfr_tb_pkg, the checker module and the block itself
module meter_reply_frame_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mrfr_pkg::*;
    import mrfr_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 400;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;    // check_ok, reply_kept, saved_reply, register_count, pad
    logic [0:0]  m_tuser;    // frame_kind

    int          fail_count;
    int          replies_owed;

    logic [7:0]  cur_header;
    logic [7:0]  cur_offset;
    int          frame_bytes;
    bit          calm;
    int          hold_seq;

    meter_reply_frame_receiver u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    meter_reply_frame_receiver_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .replies_owed (replies_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("meter_reply_frame_receiver_tb: done, errors");
                $finish;
            end
        end
    end

    // result side: short random stalls, plus one long hold on request
    initial
    begin : sink
        int hold_seen;
        hold_seen = 0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic reg_write(input logic regsel, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] hdr, input logic [7:0] ofs);
        reg_write(REG_HEADER, hdr);
        reg_write(REG_OFFSET, ofs);
        cur_header = hdr;
        cur_offset = ofs;
    endtask

    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop sending until every result word is out, then let the pipeline settle
    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (replies_owed != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_frame(input bit is_read, input logic [7:0] count, input bit bad_check);
        logic [7:0] frame_q[$];
        logic [7:0] sum;
        logic [7:0] chk;
        frame_q.push_back(cur_header);
        frame_q.push_back({4'($urandom), is_read ? CMD_READ : CMD_WRITE});
        if (is_read)
        begin
            frame_q.push_back(count);
            repeat (4 * int'(count)) frame_q.push_back(8'($urandom));
        end
        else
            frame_q.push_back(8'($urandom));
        sum = '0;
        foreach (frame_q[i])
            sum = sum + frame_q[i];
        chk = ~sum + cur_offset;
        if (bad_check)
            chk = chk ^ 8'($urandom_range(1, 255));
        frame_q.push_back(chk);
        frame_bytes += frame_q.size();
        foreach (frame_q[i])
            push_byte(frame_q[i]);
    endtask

    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            do
                b = 8'($urandom);
            while (b == cur_header && $urandom_range(0, 3) != 0);
            push_byte(b);
        end
    endtask

    task automatic run_traffic(input int amount);
        int         stop;
        int         pick;
        logic [7:0] cmd;
        stop = frame_bytes + amount;
        while (frame_bytes < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_frame(1'b0, 8'h00, $urandom_range(0, 6) == 0);
            else if (pick < 80)
                send_frame(1'b1, 8'($urandom_range(0, 3)), $urandom_range(0, 6) == 0);
            else if (pick < 86)
                send_frame(1'b1, 8'($urandom_range(4, 24)), $urandom_range(0, 6) == 0);
            else if (pick < 92)
            begin
                do
                    cmd = 8'($urandom);
                while (cmd[3:0] == CMD_READ || cmd[3:0] == CMD_WRITE);
                push_byte(cur_header);
                push_byte(cmd);
                frame_bytes += 2;
            end
            else if (pick < 95)
            begin
                // frame cut short after its command byte
                push_byte(cur_header);
                push_byte({4'($urandom), CMD_WRITE});
                frame_bytes += 2;
            end
            else
                send_noise($urandom_range(1, 4));
            if ($urandom_range(0, 4) == 0)
                send_noise($urandom_range(1, 3));
            if ($urandom_range(0, 40) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        calm <= 1'b0;
        hold_seq <= 0;
        cur_header = HEADER_RESET;
        cur_offset = OFFSET_RESET;
        frame_bytes = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes while hunting, header as command, each frame kind
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(HEADER_RESET);
        push_byte(HEADER_RESET);
        send_frame(1'b0, 8'h00, 1'b0);
        send_frame(1'b0, 8'h00, 1'b1);
        send_frame(1'b1, 8'h00, 1'b0);
        send_frame(1'b1, 8'h01, 1'b0);
        run_traffic(230);
        drain();

        set_config(8'h00, 8'hFF);
        run_traffic(200);
        drain();

        set_config(8'hFF, 8'h00);
        send_frame(1'b1, 8'h30, 1'b0);
        run_traffic(80);
        hold_seq <= hold_seq + 1;
        run_traffic(120);
        drain();

        set_config(8'($urandom), 8'($urandom));
        calm <= 1'b1;
        run_traffic(150);

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (replies_owed != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("meter_reply_frame_receiver_tb: done, clean");
        else
            $display("meter_reply_frame_receiver_tb: done, errors");
        $finish;
    end

endmodule
